FILE: rtl/core/pf_pkg.sv
// Shared types, constants and the control store of the prime factorizer.
`timescale 1ns / 1ps

package pf_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int EXP_W = 5;
  localparam int PC_W = 4;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_SMALL,
    C_DBUSY,
    C_Q_LT_D,
    C_NDIV,
    C_DIVIDES,
    C_OFULL,
    C_REM_ONE
  } cond_t;

  typedef enum logic [2:0] {
    A_NOP,
    A_LOAD,
    A_DSTART,
    A_LDQ,
    A_INC,
    A_EMIT_F,
    A_EMIT_R,
    A_EMIT_B
  } act_t;

  typedef struct packed {
    cond_t            hold;
    act_t             act;
    cond_t            jmp;
    logic [PC_W-1:0]  tgt;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic small_val;
    logic dbusy;
    logic q_lt_d;
    logic ndiv;
    logic ofull;
    logic rem_one;
  } status_t;

  localparam logic [PC_W-1:0] ST_WAIT    = 4'd0;
  localparam logic [PC_W-1:0] ST_CHK     = 4'd1;
  localparam logic [PC_W-1:0] ST_TEST    = 4'd2;
  localparam logic [PC_W-1:0] ST_TWAIT   = 4'd3;
  localparam logic [PC_W-1:0] ST_DIVCHK  = 4'd4;
  localparam logic [PC_W-1:0] ST_EXLOOP  = 4'd5;
  localparam logic [PC_W-1:0] ST_EXSTART = 4'd6;
  localparam logic [PC_W-1:0] ST_EXWAIT  = 4'd7;
  localparam logic [PC_W-1:0] ST_EMIT    = 4'd8;
  localparam logic [PC_W-1:0] ST_INC     = 4'd9;
  localparam logic [PC_W-1:0] ST_REST    = 4'd10;
  localparam logic [PC_W-1:0] ST_BAD     = 4'd11;

  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t c;
    c = '{hold: C_NEVER, act: A_NOP, jmp: C_ALWAYS, tgt: ST_WAIT};
    unique case (pc)
      ST_WAIT:    c = '{hold: C_NO_IN,  act: A_LOAD,   jmp: C_NEVER,   tgt: ST_WAIT};
      ST_CHK:     c = '{hold: C_NEVER,  act: A_NOP,    jmp: C_SMALL,   tgt: ST_BAD};
      ST_TEST:    c = '{hold: C_NEVER,  act: A_DSTART, jmp: C_NEVER,   tgt: ST_WAIT};
      ST_TWAIT:   c = '{hold: C_DBUSY,  act: A_NOP,    jmp: C_Q_LT_D,  tgt: ST_REST};
      ST_DIVCHK:  c = '{hold: C_NEVER,  act: A_NOP,    jmp: C_NDIV,    tgt: ST_INC};
      ST_EXLOOP:  c = '{hold: C_NEVER,  act: A_LDQ,    jmp: C_NEVER,   tgt: ST_WAIT};
      ST_EXSTART: c = '{hold: C_NEVER,  act: A_DSTART, jmp: C_NEVER,   tgt: ST_WAIT};
      ST_EXWAIT:  c = '{hold: C_DBUSY,  act: A_NOP,    jmp: C_DIVIDES, tgt: ST_EXLOOP};
      ST_EMIT:    c = '{hold: C_OFULL,  act: A_EMIT_F, jmp: C_REM_ONE, tgt: ST_WAIT};
      ST_INC:     c = '{hold: C_NEVER,  act: A_INC,    jmp: C_ALWAYS,  tgt: ST_TEST};
      ST_REST:    c = '{hold: C_OFULL,  act: A_EMIT_R, jmp: C_ALWAYS,  tgt: ST_WAIT};
      ST_BAD:     c = '{hold: C_OFULL,  act: A_EMIT_B, jmp: C_ALWAYS,  tgt: ST_WAIT};
      default:    c = '{hold: C_NEVER,  act: A_NOP,    jmp: C_ALWAYS,  tgt: ST_WAIT};
    endcase
    return c;
  endfunction

  function automatic logic cond_true(input cond_t c, input status_t s);
    logic t;
    t = 1'b0;
    unique case (c)
      C_NEVER:   t = 1'b0;
      C_ALWAYS:  t = 1'b1;
      C_NO_IN:   t = !s.in_valid;
      C_SMALL:   t = s.small_val;
      C_DBUSY:   t = s.dbusy;
      C_Q_LT_D:  t = s.q_lt_d;
      C_NDIV:    t = s.ndiv;
      C_DIVIDES: t = !s.ndiv;
      C_OFULL:   t = s.ofull;
      C_REM_ONE: t = s.rem_one;
      default:   t = 1'b0;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/core/prime_factorizer.sv
// Top level of the trial-division prime factorizer with its datapath.
// Each trial divisor that does not divide the rest costs one division on the shared
// divider plus the TEST, TWAIT, DIVCHK and INC sequencer steps.
// Items are worked one at a time; a value below two jumps from CHK to the error beat.
// Synchronous active-low reset returns the sequencer to its wait step and clears out_valid.
`timescale 1ns / 1ps

module prime_factorizer #(
  parameter int VALUE_BITS = pf_pkg::VALUE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [VALUE_BITS-1:0]    in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [VALUE_BITS-1:0]    out_prime,
  output logic [pf_pkg::EXP_W-1:0] out_exponent,
  output logic                     out_bad_input,
  output logic                     out_last
);

  import pf_pkg::*;

  localparam logic [VALUE_BITS-1:0] ONE = VALUE_BITS'(1);
  localparam logic [VALUE_BITS-1:0] TWO = VALUE_BITS'(2);

  ctl_t                  ctl;
  status_t               status;
  logic                  fire;
  logic                  div_busy;
  logic [VALUE_BITS-1:0] div_q;
  logic [VALUE_BITS-1:0] div_r;
  logic                  div_start;

  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [VALUE_BITS-1:0] d_r, d_nxt;
  logic [EXP_W-1:0]      e_r, e_nxt;

  logic                  ov_r, ov_nxt;
  logic [VALUE_BITS-1:0] op_r, op_nxt;
  logic [EXP_W-1:0]      oe_r, oe_nxt;
  logic                  ob_r, ob_nxt;
  logic                  ol_r, ol_nxt;

  assign status.in_valid  = in_valid;
  assign status.small_val = rem_r < TWO;
  assign status.dbusy     = div_busy;
  assign status.q_lt_d    = div_q < d_r;
  assign status.ndiv      = div_r != '0;
  assign status.ofull     = ov_r && !out_ready;
  assign status.rem_one   = rem_r == ONE;

  pf_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctl    (ctl),
    .fire   (fire)
  );

  assign div_start = fire && (ctl.act == A_DSTART);

  pf_div #(.W(VALUE_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rem_r),
    .divisor  (d_r),
    .busy     (div_busy),
    .quot     (div_q),
    .rem      (div_r)
  );

  assign in_ready = (ctl.act == A_LOAD);

  always_comb begin
    rem_nxt = rem_r;
    d_nxt   = d_r;
    e_nxt   = e_r;
    ov_nxt  = ov_r && !out_ready;
    op_nxt  = op_r;
    oe_nxt  = oe_r;
    ob_nxt  = ob_r;
    ol_nxt  = ol_r;
    if (fire) begin
      unique case (ctl.act)
        A_NOP:    ;
        A_DSTART: ;
        A_LOAD: begin
          rem_nxt = in_value;
          d_nxt   = TWO;
          e_nxt   = '0;
        end
        A_LDQ: begin
          rem_nxt = div_q;
          e_nxt   = e_r + EXP_W'(1);
        end
        A_INC: begin
          d_nxt = d_r + ONE;
          e_nxt = '0;
        end
        A_EMIT_F: begin
          ov_nxt = 1'b1;
          op_nxt = d_r;
          oe_nxt = e_r;
          ob_nxt = 1'b0;
          ol_nxt = rem_r == ONE;
        end
        A_EMIT_R: begin
          ov_nxt = 1'b1;
          op_nxt = rem_r;
          oe_nxt = EXP_W'(1);
          ob_nxt = 1'b0;
          ol_nxt = 1'b1;
        end
        A_EMIT_B: begin
          ov_nxt = 1'b1;
          op_nxt = '0;
          oe_nxt = '0;
          ob_nxt = 1'b1;
          ol_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
    op_r  <= op_nxt;
    oe_r  <= oe_nxt;
    ob_r  <= ob_nxt;
    ol_r  <= ol_nxt;
  end

  assign out_valid     = ov_r;
  assign out_prime     = op_r;
  assign out_exponent  = oe_r;
  assign out_bad_input = ob_r;
  assign out_last      = ol_r;

endmodule

FILE: rtl/core/pf_div.sv
// Restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps

module pf_div #(
  parameter int W = pf_pkg::VALUE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);
  localparam logic [CW-1:0] CNT_INIT = CW'(W);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  r_r, r_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  assign trial = {r_r, q_r[W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      cnt_nxt  = CNT_INIT;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      r_nxt   = ge ? diff[W-1:0] : trial[W-1:0];
      q_nxt   = {q_r[W-2:0], ge};
      cnt_nxt = cnt_r - CNT_ONE;
      if (cnt_r == CNT_ONE) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

FILE: rtl/core/pf_useq.sv
// Microcode sequencer: step counter, control store lookup, hold conditions and conditional jumps.
`timescale 1ns / 1ps

module pf_useq (
  input  logic              clk,
  input  logic              rst_n,
  input  pf_pkg::status_t   status,
  output pf_pkg::ctl_t      ctl,
  output logic              fire
);

  import pf_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            hold;
  logic            take;

  always_comb begin
    ctl  = ucode(pc_r);
    hold = cond_true(ctl.hold, status);
    take = cond_true(ctl.jmp, status);
    fire = !hold;
    if (hold) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = ctl.tgt;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: rtl/core/prime_factorizer_chk.sv
// Port-level assertions for the prime factorizer and their bind to the top level.
`timescale 1ns / 1ps

module prime_factorizer_chk #(
  parameter int VALUE_BITS = pf_pkg::VALUE_BITS_DEF
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [VALUE_BITS-1:0]    out_prime,
  input logic [pf_pkg::EXP_W-1:0] out_exponent,
  input logic                     out_bad_input,
  input logic                     out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_prime) && $stable(out_last))
    else $error("result beat changed while stalled");

  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_input |-> out_last && out_prime == '0 && out_exponent == '0)
    else $error("error beat is malformed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a number is in work");

  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready before the final result beat");

endmodule

bind prime_factorizer prime_factorizer_chk #(.VALUE_BITS(VALUE_BITS)) u_chk (.*);
